// ----- hw/rtl/channel_phase_difference_macros.svh -----
// ----------------------------------------------------------------------------
// Channel phase difference: assertion macros
// Shared concurrent assertion forms for the block's own checks.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_PHASE_DIFFERENCE_MACROS_SVH
`define CHANNEL_PHASE_DIFFERENCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: package
// Widths, constants, control types and the arctangent table.
// ----------------------------------------------------------------------------
package cpd_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int PROD_W       = 2 * SAMPLE_W;
	localparam int PART_W       = PROD_W + 1;
	localparam int ACC_W        = 48;
	localparam int VEC_W        = 64;
	localparam int NORM_BIT     = 59;
	localparam int ANG_W        = 25;
	localparam int OUT_W        = 16;
	localparam int CORDIC_STEPS = 22;
	localparam int STEP_W       = 5;
	localparam int ATAN_W       = 21;
	localparam int ANGLE_180    = 180 * 32768;
	localparam int ROUND_HALF   = 128;
	localparam int FRAC_SHIFT   = 8;
	localparam int OUT_LIMIT    = 23040;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_RQ,
		ST_ACC_RE,
		ST_MUL_IC,
		ST_MUL_IQ,
		ST_ACC_IM,
		ST_START,
		ST_ANGLE
	} cpd_state_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_NORM,
		CS_ROT,
		CS_FIN
	} cordic_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL_LOAD,
		OP_MUL_ADD,
		OP_MUL_SUB,
		OP_ACC_REAL,
		OP_ACC_IMAG,
		OP_CLEAR
	} mac_op_t;

	typedef struct packed {
		logic    capture;
		mac_op_t op;
		logic    a_is_q;
		logic    b_is_q;
	} mac_ctrl_t;

	function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 21'd1474560;
			5'd1:    v = 21'd870484;
			5'd2:    v = 21'd459940;
			5'd3:    v = 21'd233473;
			5'd4:    v = 21'd117189;
			5'd5:    v = 21'd58652;
			5'd6:    v = 21'd29333;
			5'd7:    v = 21'd14667;
			5'd8:    v = 21'd7334;
			5'd9:    v = 21'd3667;
			5'd10:   v = 21'd1833;
			5'd11:   v = 21'd917;
			5'd12:   v = 21'd458;
			5'd13:   v = 21'd229;
			5'd14:   v = 21'd115;
			5'd15:   v = 21'd57;
			5'd16:   v = 21'd29;
			5'd17:   v = 21'd14;
			5'd18:   v = 21'd7;
			5'd19:   v = 21'd4;
			5'd20:   v = 21'd2;
			5'd21:   v = 21'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/cpd_sample_if.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: sample channel
// Valid/ready channel carrying one reference and one compared I/Q sample.
// ----------------------------------------------------------------------------
interface cpd_sample_if;
	import cpd_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] ref_i;
	logic signed [SAMPLE_W-1:0] ref_q;
	logic signed [SAMPLE_W-1:0] chan_i;
	logic signed [SAMPLE_W-1:0] chan_q;
	logic                       last_sample;

	modport source (output valid, ref_i, ref_q, chan_i, chan_q, last_sample, input ready);
	modport sink (input valid, ref_i, ref_q, chan_i, chan_q, last_sample, output ready);

endinterface

// ----- hw/rtl/cpd_phase_if.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: phase channel
// Valid/ready channel carrying one phase estimate.
// ----------------------------------------------------------------------------
interface cpd_phase_if;
	import cpd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] phase_angle;

	modport source (output valid, phase_angle, input ready);
	modport sink (input valid, phase_angle, output ready);

endinterface

// ----- hw/rtl/cpd_accum.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: cross-product accumulator
// One shared multiplier builds each part of the conjugate product from two
// products in turn; a saturating adder folds it into the wide sums.
// ----------------------------------------------------------------------------
module cpd_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cpd_pkg::mac_ctrl_t                   ctrl,
	input  logic signed [cpd_pkg::SAMPLE_W-1:0]  ref_i,
	input  logic signed [cpd_pkg::SAMPLE_W-1:0]  ref_q,
	input  logic signed [cpd_pkg::SAMPLE_W-1:0]  chan_i,
	input  logic signed [cpd_pkg::SAMPLE_W-1:0]  chan_q,
	output logic signed [cpd_pkg::ACC_W-1:0]     sum_real,
	output logic signed [cpd_pkg::ACC_W-1:0]     sum_imag
);
	import cpd_pkg::*;

	logic signed [SAMPLE_W-1:0] ri_q, rq_q, ci_q, cq_q;
	logic signed [SAMPLE_W-1:0] op_a, op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PART_W-1:0]   prod_ext;
	logic signed [PART_W-1:0]   part_q;
	logic signed [ACC_W-1:0]    sum_real_q, sum_imag_q;
	logic signed [ACC_W-1:0]    acc_sel;
	logic signed [ACC_W:0]      acc_raw;
	logic signed [ACC_W-1:0]    acc_sat;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			ri_q <= ref_i;
			rq_q <= ref_q;
			ci_q <= chan_i;
			cq_q <= chan_q;
		end
	end

	assign op_a     = ctrl.a_is_q ? rq_q : ri_q;
	assign op_b     = ctrl.b_is_q ? cq_q : ci_q;
	assign prod     = op_a * op_b;
	assign prod_ext = PART_W'(prod);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_MUL_LOAD: part_q <= prod_ext;
			OP_MUL_ADD:  part_q <= part_q + prod_ext;
			OP_MUL_SUB:  part_q <= part_q - prod_ext;
			default:     part_q <= part_q;
		endcase
	end

	assign acc_sel = (ctrl.op == OP_ACC_IMAG) ? sum_imag_q : sum_real_q;
	assign acc_raw = (ACC_W + 1)'(acc_sel) + (ACC_W + 1)'(part_q);

	always_comb begin
		if (acc_raw[ACC_W] != acc_raw[ACC_W-1]) begin
			acc_sat = acc_raw[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
			                         : {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			acc_sat = acc_raw[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_real_q <= '0;
			sum_imag_q <= '0;
		end else begin
			case (ctrl.op)
				OP_ACC_REAL: sum_real_q <= acc_sat;
				OP_ACC_IMAG: sum_imag_q <= acc_sat;
				OP_CLEAR: begin
					sum_real_q <= '0;
					sum_imag_q <= '0;
				end
				default: begin
					sum_real_q <= sum_real_q;
					sum_imag_q <= sum_imag_q;
				end
			endcase
		end
	end

	assign sum_real = sum_real_q;
	assign sum_imag = sum_imag_q;

endmodule

// ----- hw/rtl/cpd_cordic.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: arctangent unit
// Pre-rotates and normalises the sums one bit per cycle, then runs one
// CORDIC vectoring step per cycle and rounds the angle to 1/128 degree.
// ----------------------------------------------------------------------------
module cpd_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                res_free,
	input  logic signed [cpd_pkg::ACC_W-1:0]    sum_real,
	input  logic signed [cpd_pkg::ACC_W-1:0]    sum_imag,
	output logic                                done,
	output logic signed [cpd_pkg::OUT_W-1:0]    angle
);
	import cpd_pkg::*;

	localparam logic signed [ANG_W-1:0] Angle180 = ANG_W'(ANGLE_180);
	localparam logic signed [ANG_W-1:0] Limit    = ANG_W'(OUT_LIMIT);

	cordic_state_t state_q, state_d;

	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [STEP_W-1:0]       step_q;

	logic signed [VEC_W-1:0] xs, ys, ay, dx, dy;
	logic signed [ANG_W-1:0] atan_ext, tot, shr;
	logic                    is_zero, below_norm;

	assign xs         = VEC_W'(sum_real);
	assign ys         = VEC_W'(sum_imag);
	assign is_zero    = (sum_real == '0) && (sum_imag == '0);
	assign ay         = y_q[VEC_W-1] ? -y_q : y_q;
	assign below_norm = (x_q[VEC_W-1:NORM_BIT] == '0) && (ay[VEC_W-1:NORM_BIT] == '0);
	assign dx         = y_q >>> step_q;
	assign dy         = x_q >>> step_q;
	assign atan_ext   = ANG_W'(atan_entry(step_q));
	assign tot        = z_q + ANG_W'(ROUND_HALF);
	assign shr        = tot >>> FRAC_SHIFT;

	always_comb begin
		if (shr > Limit) begin
			angle = OUT_W'(Limit);
		end else if (shr < -Limit) begin
			angle = OUT_W'(-Limit);
		end else begin
			angle = shr[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CS_ROT) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = is_zero ? CS_FIN : CS_NORM;
				end
			end
			CS_NORM: begin
				if (!below_norm) begin
					state_d = CS_ROT;
				end
			end
			CS_ROT: begin
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = CS_FIN;
				end
			end
			CS_FIN: begin
				if (res_free) begin
					done    = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					if (xs[VEC_W-1]) begin
						x_q <= -xs;
						y_q <= -ys;
						z_q <= ys[VEC_W-1] ? -Angle180 : Angle180;
					end else begin
						x_q <= xs;
						y_q <= ys;
						z_q <= '0;
					end
				end
			end
			CS_NORM: begin
				if (below_norm) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			CS_ROT: begin
				if (!y_q[VEC_W-1]) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_ext;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_ext;
				end
			end
			default: begin
				x_q <= x_q;
				y_q <= y_q;
				z_q <= z_q;
			end
		endcase
	end

endmodule

// ----- hw/rtl/channel_phase_difference.sv -----
// ----------------------------------------------------------------------------
// Channel phase difference: top level
// Accumulates the conjugate cross-product of two I/Q channels over a window
// and gives the phase of the compared channel relative to the reference.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  samples   in         ref_i, ref_q, chan_i, chan_q, last_sample
//  phase     out        phase_angle (1/128 degree, registered)
//
// An item not marked last is captured, then the shared multiplier forms the
// four products one after another, each pair folded into its sum. A last item
// then clears the sums and loads the arctangent unit, which normalises, runs
// the CORDIC steps and hands the angle to the output register; when both sums
// are zero only that hand-over follows the load.
// A result waiting on a stalled sink holds the arctangent unit, while the output
// register lets the next window start as soon as it is free. Reset clears the
// state machines, the output valid flag and the sums.
module channel_phase_difference (
	input  logic        clk,
	input  logic        arst_n,
	cpd_sample_if.sink  samples,
	cpd_phase_if.source phase
);
	import cpd_pkg::*;
	`include "channel_phase_difference_macros.svh"

	cpd_state_t state_q, state_d;
	mac_ctrl_t  mac_ctrl;
	logic       last_q;
	logic       start;
	logic       res_free;
	logic       ang_done;

	logic signed [ACC_W-1:0] sum_real, sum_imag;
	logic signed [OUT_W-1:0] angle;
	logic signed [OUT_W-1:0] out_angle_q;
	logic                    out_valid_q;

	cpd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.ref_i    (samples.ref_i),
		.ref_q    (samples.ref_q),
		.chan_i   (samples.chan_i),
		.chan_q   (samples.chan_q),
		.sum_real (sum_real),
		.sum_imag (sum_imag)
	);

	cpd_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.res_free (res_free),
		.sum_real (sum_real),
		.sum_imag (sum_imag),
		.done     (ang_done),
		.angle    (angle)
	);

	assign res_free = !out_valid_q || phase.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			last_q <= samples.last_sample;
		end
	end

	always_comb begin
		state_d          = state_q;
		samples.ready    = 1'b0;
		start            = 1'b0;
		mac_ctrl.capture = 1'b0;
		mac_ctrl.op      = OP_NONE;
		mac_ctrl.a_is_q  = 1'b0;
		mac_ctrl.b_is_q  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready    = 1'b1;
				mac_ctrl.capture = samples.valid;
				if (samples.valid) begin
					state_d = ST_MUL_RR;
				end
			end
			ST_MUL_RR: begin
				mac_ctrl.op = OP_MUL_LOAD;
				state_d     = ST_MUL_RQ;
			end
			ST_MUL_RQ: begin
				mac_ctrl.op     = OP_MUL_ADD;
				mac_ctrl.a_is_q = 1'b1;
				mac_ctrl.b_is_q = 1'b1;
				state_d         = ST_ACC_RE;
			end
			ST_ACC_RE: begin
				mac_ctrl.op = OP_ACC_REAL;
				state_d     = ST_MUL_IC;
			end
			ST_MUL_IC: begin
				mac_ctrl.op     = OP_MUL_LOAD;
				mac_ctrl.b_is_q = 1'b1;
				state_d         = ST_MUL_IQ;
			end
			ST_MUL_IQ: begin
				mac_ctrl.op     = OP_MUL_SUB;
				mac_ctrl.a_is_q = 1'b1;
				state_d         = ST_ACC_IM;
			end
			ST_ACC_IM: begin
				mac_ctrl.op = OP_ACC_IMAG;
				state_d     = last_q ? ST_START : ST_IDLE;
			end
			ST_START: begin
				mac_ctrl.op = OP_CLEAR;
				start       = 1'b1;
				state_d     = ST_ANGLE;
			end
			ST_ANGLE: begin
				if (ang_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ang_done) begin
			out_valid_q <= 1'b1;
		end else if (phase.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ang_done) begin
			out_angle_q <= angle;
		end
	end

	assign phase.valid       = out_valid_q;
	assign phase.phase_angle = out_angle_q;

	`CPD_ASSERT_NOW(a_done_in_angle, clk, arst_n, ang_done, state_q == ST_ANGLE, "angle finished outside a window end")
	`CPD_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !phase.ready, !ang_done, "pending transaction overwritten")
	`CPD_ASSERT_NEXT(a_sums_cleared, clk, arst_n, state_q == ST_START, (sum_real == '0) && (sum_imag == '0), "sums not cleared at window end")
	`CPD_ASSERT_NOW(a_angle_range, clk, arst_n, phase.valid, (phase.phase_angle <= 16'sd23040) && (phase.phase_angle >= -16'sd23040), "phase outside range")

endmodule
